// ----- rtl/gate_cv_to_note_events_top_defines.svh -----
// Assertion helpers for the gate/CV to note event block.
`ifndef GATE_CV_TO_NOTE_EVENTS_TOP_DEFINES_SVH
`define GATE_CV_TO_NOTE_EVENTS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// check that is off while reset is held
`define GCNE_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("gcne check failed");
// check that also covers the reset cycles
`define GCNE_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge i_clk) prop) \
        else $error("gcne reset check failed");
`else
`define GCNE_ASSERT(name, prop)
`define GCNE_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ----- rtl/gcne_pkg.sv -----
package gcne_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int NOTE_BITS       = 7;
    localparam int VEL_BITS        = 15;
    localparam int CHAN_BITS       = 4;
    localparam int NOTE_MAX        = 127;
    localparam int VEL_MIN         = 258;
    localparam int VEL_MAX         = 32767;
    localparam int VEL_OFF         = 16384;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 4;

    localparam logic [63:0] RATIO_DEN = 64'd250000000000;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MIDI_CHANNEL = 2'd0,
        CFG_PITCH_MODE   = 2'd1
    } t_cfg_reg;

    typedef enum logic {
        EV_NOTE_OFF = 1'b0,
        EV_NOTE_ON  = 1'b1
    } t_event_kind;

    typedef struct packed {
        logic [CHAN_BITS-1:0] channel;
        logic                 exp_mode;   // 1: volt per kilohertz
    } t_cfg;

    // equal-tempered semitone ratios, scaled by 1e9
    function automatic logic [63:0] semitone_ratio(input int k);
        logic [63:0] r;
        case (k)
            0:       r = 64'd1000000000;
            1:       r = 64'd1059463094;
            2:       r = 64'd1122462048;
            3:       r = 64'd1189207115;
            4:       r = 64'd1259921050;
            5:       r = 64'd1334839854;
            6:       r = 64'd1414213562;
            7:       r = 64'd1498307077;
            8:       r = 64'd1587401052;
            9:       r = 64'd1681792831;
            10:      r = 64'd1781797436;
            11:      r = 64'd1887748625;
            default: r = 64'd1000000000;
        endcase
        return r;
    endfunction

    // ceil(440 * 2^((n-69)/12) / 10000 * 2^(sb-1)), elaboration time only
    function automatic logic [63:0] note_threshold(input int n, input int sb);
        int          sh;
        int          k;
        int          oct;
        logic [63:0] num;
        logic [63:0] q;
        sh  = n + 3;
        k   = sh % 12;
        oct = sh / 12 - 6;
        num = 64'd11 * (64'd1 << (sb - 1)) * semitone_ratio(k);
        if (oct >= 0) begin
            num = num << oct;
            q   = (num + RATIO_DEN - 64'd1) / RATIO_DEN;
        end else begin
            q = (num + RATIO_DEN - 64'd1) / RATIO_DEN;
            q = (q + (64'd1 << (-oct)) - 64'd1) >> (-oct);
        end
        return q;
    endfunction

endpackage

// ----- rtl/gcne_if.sv -----
interface gcne_frame_if
    import gcne_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] gate_level;
    logic signed [SAMPLE_BITS-1:0] pitch_level;
    logic signed [SAMPLE_BITS-1:0] velocity_level;

    modport source (output valid, gate_level, pitch_level, velocity_level, input ready);
    modport sink   (input valid, gate_level, pitch_level, velocity_level, output ready);
endinterface

interface gcne_event_if
    import gcne_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 event_kind;
    logic [NOTE_BITS-1:0] note_number;
    logic [VEL_BITS-1:0]  note_velocity;
    logic [CHAN_BITS-1:0] event_channel;

    modport source (output valid, event_kind, note_number, note_velocity, event_channel,
                    input ready);
    modport sink   (input valid, event_kind, note_number, note_velocity, event_channel,
                    output ready);
endinterface

// ----- rtl/gcne_note_conv.sv -----
module gcne_note_conv
    import gcne_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0] i_pitch,
    input  logic signed [SAMPLE_BITS-1:0] i_velocity,
    input  logic                          i_exp_mode,
    output logic [NOTE_BITS-1:0]          o_note,
    output logic [VEL_BITS-1:0]           o_velocity
);

    localparam int LW = SAMPLE_BITS + 8;
    localparam logic signed [LW-1:0] LIN_OFS = LW'(19 * (2 ** (SAMPLE_BITS - 2)));

    // volt per octave: floor((19*FS/2 + 120*pitch) / FS)
    logic signed [LW-1:0] w_lin;
    logic [8:0]           w_lin_q;
    logic [NOTE_BITS-1:0] w_lin_note;

    assign w_lin   = LIN_OFS + $signed(LW'(120)) * $signed({{8{i_pitch[SAMPLE_BITS-1]}}, i_pitch});
    assign w_lin_q = w_lin[SAMPLE_BITS+7:SAMPLE_BITS-1];

    always_comb begin
        if (w_lin[LW-1]) begin
            w_lin_note = '0;
        end else if (w_lin_q > 9'(NOTE_MAX)) begin
            w_lin_note = NOTE_BITS'(NOTE_MAX);
        end else begin
            w_lin_note = w_lin_q[NOTE_BITS-1:0];
        end
    end

    // volt per kilohertz: thresholds rise with n, so the compares form a
    // thermometer code; its top edge is the note
    logic [NOTE_MAX+1:1] w_thermo;
    logic [NOTE_MAX:1]   w_hot;
    logic [NOTE_BITS-1:0] w_exp_note;

    assign w_thermo[NOTE_MAX+1] = 1'b0;

    for (genvar n = 1; n <= NOTE_MAX; n++) begin : g_thr
        localparam logic [SAMPLE_BITS:0] TH = (SAMPLE_BITS+1)'(note_threshold(n, SAMPLE_BITS));
        assign w_thermo[n] = $signed({1'b0, TH}) <= $signed({i_pitch[SAMPLE_BITS-1], i_pitch});
        assign w_hot[n]    = w_thermo[n] & ~w_thermo[n+1];
    end

    always_comb begin
        w_exp_note = '0;
        for (int n = 1; n <= NOTE_MAX; n++) begin
            if (w_hot[n]) begin
                w_exp_note = w_exp_note | NOTE_BITS'(n);
            end
        end
    end

    assign o_note = i_exp_mode ? w_exp_note : w_lin_note;

    // velocity to Q0.15: v * 2^16 / 2^SAMPLE_BITS, then clamp
    logic [15:0] w_vq;

    assign w_vq = 16'({i_velocity, 16'b0} >> SAMPLE_BITS);

    always_comb begin
        if (i_velocity[SAMPLE_BITS-1] || (i_velocity == '0) || (w_vq < 16'(VEL_MIN))) begin
            o_velocity = VEL_BITS'(VEL_MIN);
        end else if (w_vq > 16'(VEL_MAX)) begin
            o_velocity = VEL_BITS'(VEL_MAX);
        end else begin
            o_velocity = w_vq[VEL_BITS-1:0];
        end
    end

endmodule

// ----- rtl/gcne_core.sv -----
`include "gate_cv_to_note_events_top_defines.svh"

module gcne_core
    import gcne_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    gcne_frame_if.sink   i_frame,
    gcne_event_if.source o_event
);

    // input stage
    logic                          r_s1_valid;
    logic                          r_s1_gate;
    logic signed [SAMPLE_BITS-1:0] r_s1_pitch;
    logic signed [SAMPLE_BITS-1:0] r_s1_vel;

    // block state
    logic                 r_gate_high;
    logic [NOTE_BITS-1:0] r_held_note;

    // result stage
    logic                 r_out_valid;
    t_event_kind          r_out_kind;
    logic [NOTE_BITS-1:0] r_out_note;
    logic [VEL_BITS-1:0]  r_out_vel;
    logic [CHAN_BITS-1:0] r_out_ch;

    logic                 w_in_take;
    logic                 w_out_free;
    logic                 w_fire;
    logic                 w_s1_move;
    logic                 w_out_load;
    logic [NOTE_BITS-1:0] w_note;
    logic [VEL_BITS-1:0]  w_vel;

    gcne_note_conv #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_conv (
        .i_pitch    (r_s1_pitch),
        .i_velocity (r_s1_vel),
        .i_exp_mode (i_cfg.exp_mode),
        .o_note     (w_note),
        .o_velocity (w_vel)
    );

    assign w_out_free    = !r_out_valid || o_event.ready;
    assign w_fire        = r_s1_gate != r_gate_high;
    // a beat that makes no event leaves even while the result slot is full
    assign w_s1_move     = r_s1_valid && (!w_fire || w_out_free);
    assign w_out_load    = w_s1_move && w_fire;
    assign i_frame.ready = !r_s1_valid || w_s1_move;
    assign w_in_take     = i_frame.valid && i_frame.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_take) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_gate  <= !i_frame.gate_level[SAMPLE_BITS-1] && (i_frame.gate_level != '0);
            r_s1_pitch <= i_frame.pitch_level;
            r_s1_vel   <= i_frame.velocity_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_high <= 1'b0;
            r_held_note <= '0;
        end else if (w_out_load) begin
            r_gate_high <= r_s1_gate;
            if (r_s1_gate) begin
                r_held_note <= w_note;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_event.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_ch <= i_cfg.channel;
            if (r_s1_gate) begin
                r_out_kind <= EV_NOTE_ON;
                r_out_note <= w_note;
                r_out_vel  <= w_vel;
            end else begin
                r_out_kind <= EV_NOTE_OFF;
                r_out_note <= r_held_note;
                r_out_vel  <= VEL_BITS'(VEL_OFF);
            end
        end
    end

    assign o_event.valid         = r_out_valid;
    assign o_event.event_kind    = r_out_kind;
    assign o_event.note_number   = r_out_note;
    assign o_event.note_velocity = r_out_vel;
    assign o_event.event_channel = r_out_ch;

    `GCNE_ASSERT(a_off_velocity, (r_out_valid && r_out_kind == EV_NOTE_OFF) |-> (r_out_vel == VEL_BITS'(VEL_OFF)))
    `GCNE_ASSERT(a_on_velocity, (r_out_valid && r_out_kind == EV_NOTE_ON) |-> (r_out_vel >= VEL_BITS'(VEL_MIN)))
    `GCNE_ASSERT(a_kind_tracks_gate, w_out_load |=> (r_gate_high == (r_out_kind == EV_NOTE_ON)))
    `GCNE_ASSERT(a_gate_holds, !w_out_load |=> $stable(r_gate_high))
    `GCNE_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> (!r_out_valid && !r_s1_valid))

endmodule

// ----- rtl/gate_cv_to_note_events_top.sv -----
// Gate/CV to note events. Each input beat is one frame of gate, pitch and
// velocity samples (signed, full scale = 10 V for pitch, 1.0 for velocity).
// A gate going above zero sends a note-on whose note comes from pitch
// (1 V/octave: floor((19*FS/2 + 120*pitch)/FS); 1 V/kHz: count of notes
// whose frequency threshold is at or below pitch), velocity clamped to
// 258..32767 in Q0.15. A gate falling to zero or below sends a note-off for
// the held note with velocity 16384. All other frames send nothing.
// Rate: one frame per clock, sustained, while the output is ready. While a
// result waits on a stalled output, frames that make no event keep flowing;
// the next event-making frame waits in the input register and holds off the
// input until the result slot frees up. A frame passes an input register,
// then the note conversion (127 constant compares and an encoder in kHz
// mode, one multiply-add in octave mode) into the result register.
// Configuration (channel, pitch mode) is to be written by the user through
// the plain write port only while idle; the block does not enforce this;
// writes to unknown indexes are dropped.
module gate_cv_to_note_events_top
    import gcne_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    gcne_frame_if.sink                i_frame,
    gcne_event_if.source              o_event
);

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_MIDI_CHANNEL: r_cfg.channel  <= i_cfg_data[CHAN_BITS-1:0];
                CFG_PITCH_MODE:   r_cfg.exp_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // datapath: input stage, conversion, result stage
    gcne_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_frame (i_frame),
        .o_event (o_event)
    );

endmodule
